// ===== rtl/bccd_pkg.sv =====
// Shared types and constants of the book cipher coordinate decoder.
package bccd_pkg;

  // Default geometry of the key text.
  localparam int unsigned DefWords    = 4096;
  localparam int unsigned DefWordLen  = 16;
  localparam int unsigned DefSpaceMax = 62;

  // Fixed field widths.
  localparam int unsigned FuncW  = 2;
  localparam int unsigned WidxW  = 12;
  localparam int unsigned CposW  = 4;
  localparam int unsigned CharW  = 8;
  localparam int unsigned CoordW = 14;
  localparam int unsigned CountW = 3;
  localparam int unsigned SpaceW = 6;
  localparam int unsigned FillW  = 2;

  localparam logic [CountW-1:0] MaxDigits = 3'd4;

  // Item function codes.
  localparam logic [FuncW-1:0] FuncLoad = 2'd0;
  localparam logic [FuncW-1:0] FuncChar = 2'd1;
  localparam logic [FuncW-1:0] FuncEnd  = 2'd2;

  // Characters of the cipher text.
  localparam logic [CharW-1:0] CharHash  = 8'h23;
  localparam logic [CharW-1:0] CharComma = 8'h2C;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;

  // Final character of an output job, after the lookup and the space run.
  typedef enum logic [1:0] {
    TailNone,
    TailSpace,
    TailHash
  } tail_e;

  // One item's worth of results, handed to the output sequencer.
  typedef struct packed {
    logic              lookup;
    logic              bad;
    logic [SpaceW-1:0] spaces;
    tail_e             tail;
  } bccd_job_t;

endpackage

// ===== rtl/bccd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bccd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bccd_emitter.sv =====
// Output sequencer: turns one job into its run of result words.
module bccd_emitter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_load_i,
  input  bccd_pkg::bccd_job_t      job_i,
  output logic                     job_ready_o,
  input  logic [bccd_pkg::CharW-1:0] key_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [bccd_pkg::CharW-1:0] out_char_o,
  output logic                     last_o,
  output logic                     bad_coord_o
);
  import bccd_pkg::*;

  logic       j_valid_q, j_valid_d;
  bccd_job_t  j_q, j_d;
  logic       out_valid_q, out_valid_d;
  logic [CharW-1:0] out_char_q;
  logic       last_q, bad_q;

  logic             out_free, emit, emit_last, emit_bad;
  logic [CharW-1:0] emit_char;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = j_valid_q && out_free;

  always_comb begin
    emit_char = '0;
    emit_last = 1'b0;
    emit_bad  = 1'b0;
    if (j_q.lookup) begin
      // The key byte sits in the RAM read register until the lookup leaves.
      emit_char = j_q.bad ? '0 : key_i;
      emit_bad  = j_q.bad;
      emit_last = (j_q.spaces == '0) && (j_q.tail == TailNone);
    end else if (j_q.spaces != '0) begin
      emit_char = CharSpace;
      emit_last = (j_q.spaces == SpaceW'(1)) && (j_q.tail == TailNone);
    end else begin
      case (j_q.tail)
        TailHash: emit_char = CharHash;
        default:  emit_char = CharSpace;
      endcase
      emit_last = 1'b1;
    end
  end

  always_comb begin
    j_d       = j_q;
    j_valid_d = j_valid_q;
    if (emit) begin
      j_d.lookup = 1'b0;
      if (!j_q.lookup && j_q.spaces != '0) begin
        j_d.spaces = j_q.spaces - SpaceW'(1);
      end
      if (emit_last) begin
        j_valid_d = 1'b0;
      end
    end
    if (job_load_i) begin
      j_valid_d = 1'b1;
      j_d       = job_i;
    end
  end

  assign job_ready_o = !j_valid_q || (emit && emit_last);
  assign out_valid_d = out_free ? emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      j_valid_q   <= j_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d;
    if (out_free && emit) begin
      out_char_q <= emit_char;
      last_q     <= emit_last;
      bad_q      <= emit_bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = last_q;
  assign bad_coord_o = bad_q;

`ifndef SYNTHESIS
  // A held job always has at least one word left to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_valid_q |-> (j_q.lookup || j_q.spaces != '0 || j_q.tail != TailNone))
    else $error("empty job held in sequencer");

  // A new job only arrives when the current one is gone or leaving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_load_i |-> job_ready_o)
    else $error("job overwritten before its last word");

  // An out-of-range lookup always reports a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && bad_q) |-> out_char_q == '0)
    else $error("bad coordinate with nonzero byte");

  // Once the last word of a job is sent, the sequencer is empty unless refilled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last && !job_load_i) |=> !j_valid_q)
    else $error("sequencer still busy after last word");
`endif

endmodule

// ===== rtl/book_cipher_coordinate_decoder.sv =====
// Top level of the book cipher coordinate decoder.
//
// The input channel (in_valid_i / in_stall_o) takes one word per cycle when
// not stalled: a key byte load, a cipher-text character or an end-of-stream
// mark. Loads write the key store and give no result. Characters update the
// coordinate parser; a word that resolves a completed word,position pair, a
// '#', or a space after '#' queues a job of result words: the looked-up byte,
// the pending space run, then, if due, one closing ' ' or '#'. The output
// channel (out_valid_o / out_stall_i) carries one result word per cycle when
// not stalled, with last_o on the final one. The key store is read and the
// job registered at the edge that accepts the input word; the first result
// word then passes to the output register once that register is free. A word
// with several results holds back the next one until its last result word
// leaves the sequencer, which sends one result word per cycle unless stalled.
// When the receiver stalls, the output register holds its word and the input
// stalls once the sequencer is full. Reset clears the parser and the sequencer;
// the key store is not cleared and must be loaded before it is read.
module book_cipher_coordinate_decoder #(
  parameter int unsigned WORDS     = bccd_pkg::DefWords,
  parameter int unsigned WORD_LEN  = bccd_pkg::DefWordLen,
  parameter int unsigned SPACE_MAX = bccd_pkg::DefSpaceMax
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bccd_pkg::FuncW-1:0]  func_i,
  input  logic [bccd_pkg::WidxW-1:0]  word_index_i,
  input  logic [bccd_pkg::CposW-1:0]  char_pos_i,
  input  logic [bccd_pkg::CharW-1:0]  in_char_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bccd_pkg::CharW-1:0]  out_char_o,
  output logic                        last_o,
  output logic                        bad_coord_o
);
  import bccd_pkg::*;

  localparam int unsigned Depth = WORDS * WORD_LEN;
  localparam int unsigned AddrW = Depth > 1 ? $clog2(Depth) : 1;

  logic [CoordW-1:0] digit_value_q, digit_value_d;
  logic [CountW-1:0] digit_count_q, digit_count_d;
  logic              hash_mark_q, hash_mark_d;
  logic [CoordW-1:0] first_coord_q, first_coord_d;
  logic [CoordW-1:0] second_coord_q, second_coord_d;
  logic [FillW-1:0]  pair_fill_q, pair_fill_d;
  logic [SpaceW-1:0] space_run_q, space_run_d;

  logic              job_ready, accept, job_valid, load_ok;
  bccd_job_t         job;
  logic [CoordW-1:0] look_w, look_p;
  logic [AddrW-1:0]  rd_addr, wr_addr;
  logic [CharW-1:0]  key_byte;

  assign in_stall_o = !job_ready;
  assign accept     = in_valid_i && job_ready;

  always_comb begin
    digit_value_d  = digit_value_q;
    digit_count_d  = digit_count_q;
    hash_mark_d    = hash_mark_q;
    first_coord_d  = first_coord_q;
    second_coord_d = second_coord_q;
    pair_fill_d    = pair_fill_q;
    space_run_d    = space_run_q;
    job            = '{lookup: 1'b0, bad: 1'b0, spaces: '0, tail: TailNone};
    look_w         = first_coord_q;
    look_p         = second_coord_q;

    unique case (func_i)
      FuncEnd: begin
        if (pair_fill_q >= FillW'(2)) begin
          job.lookup = 1'b1;
        end else if (pair_fill_q == FillW'(1) && digit_count_q != '0 && !hash_mark_q) begin
          job.lookup = 1'b1;
          look_p     = digit_value_q;
        end
        digit_value_d  = '0;
        digit_count_d  = '0;
        hash_mark_d    = 1'b0;
        first_coord_d  = '0;
        second_coord_d = '0;
        pair_fill_d    = '0;
        space_run_d    = '0;
      end
      FuncChar: begin
        if (space_run_q != '0 && in_char_i == CharSpace) begin
          if (space_run_q < SpaceW'(SPACE_MAX)) begin
            space_run_d = space_run_q + SpaceW'(1);
          end
        end else begin
          // A completed pair resolves first, with the spaces that followed it.
          if (pair_fill_q >= FillW'(2)) begin
            job.lookup  = 1'b1;
            job.spaces  = space_run_q;
            pair_fill_d = '0;
            space_run_d = '0;
          end
          case (in_char_i) inside
            CharSpace, CharComma: begin
              if (!hash_mark_q) begin
                if (pair_fill_d == '0) begin
                  first_coord_d = digit_value_q;
                end else begin
                  second_coord_d = digit_value_q;
                end
                if (pair_fill_d < FillW'(2)) begin
                  pair_fill_d = pair_fill_d + FillW'(1);
                end
                if (in_char_i == CharSpace) begin
                  space_run_d = SpaceW'(1);
                end
              end else begin
                if (in_char_i == CharSpace) begin
                  job.tail = TailSpace;
                end else begin
                  pair_fill_d = '0;
                end
                hash_mark_d = 1'b0;
              end
              digit_value_d = '0;
              digit_count_d = '0;
            end
            [CharZero:CharNine]: begin
              if (!hash_mark_q && digit_count_q < MaxDigits) begin
                digit_value_d = digit_value_q * 14'd10 + CoordW'(in_char_i[3:0]);
                digit_count_d = digit_count_q + CountW'(1);
              end
            end
            CharHash: begin
              job.tail      = TailHash;
              hash_mark_d   = 1'b1;
              digit_value_d = '0;
              digit_count_d = '0;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    job.bad = !(32'(look_w) < WORDS && 32'(look_p) < WORD_LEN);
  end

  assign job_valid = job.lookup || job.tail != TailNone;

  assign rd_addr = AddrW'(look_w) * AddrW'(WORD_LEN) + AddrW'(look_p);
  assign wr_addr = AddrW'(word_index_i) * AddrW'(WORD_LEN) + AddrW'(char_pos_i);
  assign load_ok = 32'(word_index_i) < WORDS && 32'(char_pos_i) < WORD_LEN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_value_q  <= '0;
      digit_count_q  <= '0;
      hash_mark_q    <= 1'b0;
      first_coord_q  <= '0;
      second_coord_q <= '0;
      pair_fill_q    <= '0;
      space_run_q    <= '0;
    end else if (accept && (func_i == FuncChar || func_i == FuncEnd)) begin
      digit_value_q  <= digit_value_d;
      digit_count_q  <= digit_count_d;
      hash_mark_q    <= hash_mark_d;
      first_coord_q  <= first_coord_d;
      second_coord_q <= second_coord_d;
      pair_fill_q    <= pair_fill_d;
      space_run_q    <= space_run_d;
    end
  end

  bccd_ram #(
    .WIDTH (CharW),
    .DEPTH (Depth)
  ) u_key_store (
    .clk_i   (clk_i),
    .we_i    (accept && func_i == FuncLoad && load_ok),
    .waddr_i (wr_addr),
    .wdata_i (in_char_i),
    .re_i    (accept && (func_i == FuncChar || func_i == FuncEnd) && job.lookup && !job.bad),
    .raddr_i (rd_addr),
    .rdata_o (key_byte)
  );

  bccd_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_load_i  (accept && (func_i == FuncChar || func_i == FuncEnd) && job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .key_i       (key_byte),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o),
    .bad_coord_o (bad_coord_o)
  );

endmodule
